/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked at every rising edge of clock outside reset
`define ASSERT_PROP(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition that must never be true outside reset
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)

`endif

`endif

/* rtl/core/dqr_pkg.sv */
// ----------------------------------------------------------------------------
// dqr_pkg
// Shared types and constants of the DNS query ID and case rewriter.
// ----------------------------------------------------------------------------
package dqr_pkg;

   localparam int HEADER_BYTES = 12;
   localparam int MAX_LABEL    = 63;
   localparam int POS_W        = 4;
   localparam int LABEL_W      = 6;

   localparam logic [15:0] FLAGS_KEEP_MASK_RESET = 16'h7900;

   // register index of the CSR space
   localparam logic [0:0] CSR_FLAGS_KEEP_MASK = 1'b0;

   // header byte positions
   localparam logic [POS_W-1:0] HDR_ID_HI      = 4'd0;
   localparam logic [POS_W-1:0] HDR_ID_LO      = 4'd1;
   localparam logic [POS_W-1:0] HDR_FLAGS_HI   = 4'd2;
   localparam logic [POS_W-1:0] HDR_FLAGS_LO   = 4'd3;
   localparam logic [POS_W-1:0] HDR_QDCOUNT_HI = 4'd4;
   localparam logic [POS_W-1:0] HDR_QDCOUNT_LO = 4'd5;

   typedef struct packed {
      logic [7:0]  query_byte;
      logic        end_of_query;
      logic [15:0] new_query_id;
      logic        random_bit;
   } item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic       short_query;
   } result_type;

endpackage

/* rtl/core/dqr_rewrite.sv */
// ----------------------------------------------------------------------------
// dqr_rewrite
// Per-byte rewrite logic and query walk state, updated on each transfer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dqr_rewrite (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  dqr_pkg::item_type   item,
   input  logic [15:0]         keep_mask,
   output dqr_pkg::result_type result
);

   typedef enum logic [3:0] {
      WALK_HEADER = 4'b0001,
      WALK_LENGTH = 4'b0010,
      WALK_LABEL  = 4'b0100,
      WALK_DONE   = 4'b1000
   } walk_mode_type;

   logic [dqr_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic                        cnt_hi_ff, cnt_hi_in;
   walk_mode_type               mode_ff, mode_in;
   logic [dqr_pkg::LABEL_W-1:0] left_ff, left_in;
   logic [dqr_pkg::LABEL_W-1:0] left_dec;
   logic                        in_header;
   logic [7:0]                  b;
   logic [7:0]                  r;
   logic                        is_letter;

   assign b         = item.query_byte;
   assign in_header = pos_ff < dqr_pkg::POS_W'(dqr_pkg::HEADER_BYTES);
   assign is_letter = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
   assign left_dec  = (left_ff != '0) ? left_ff - 1'b1 : left_ff;

   always_comb begin
      r         = b;
      pos_in    = pos_ff;
      cnt_hi_in = cnt_hi_ff;
      mode_in   = mode_ff;
      left_in   = left_ff;
      if (in_header) begin
         case (pos_ff)
            dqr_pkg::HDR_ID_HI:      r = item.new_query_id[15:8];
            dqr_pkg::HDR_ID_LO:      r = item.new_query_id[7:0];
            dqr_pkg::HDR_FLAGS_HI:   r = b & keep_mask[15:8];
            dqr_pkg::HDR_FLAGS_LO:   r = b & keep_mask[7:0];
            dqr_pkg::HDR_QDCOUNT_HI: cnt_hi_in = (b != 8'd0);
            dqr_pkg::HDR_QDCOUNT_LO: begin
               mode_in = (cnt_hi_ff || b != 8'd0) ? WALK_LENGTH : WALK_DONE;
            end
            default: r = b;
         endcase
      end else begin
         case (mode_ff)
            WALK_LENGTH: begin
               if (b == 8'd0 || b[7:6] == 2'b11 || b > 8'(dqr_pkg::MAX_LABEL)) begin
                  mode_in = WALK_DONE;
               end else begin
                  left_in = b[dqr_pkg::LABEL_W-1:0];
                  mode_in = WALK_LABEL;
               end
            end
            WALK_LABEL: begin
               if (is_letter) begin
                  r = item.random_bit ? (b & 8'hDF) : (b | 8'h20);
               end
               left_in = left_dec;
               if (left_dec == '0) begin
                  mode_in = WALK_LENGTH;
               end
            end
            default: r = b;
         endcase
      end
      if (item.end_of_query) begin
         pos_in    = '0;
         cnt_hi_in = 1'b0;
         mode_in   = WALK_HEADER;
         left_in   = '0;
      end else if (in_header) begin
         pos_in = pos_ff + 1'b1;
      end
   end

   assign result.out_byte    = r;
   assign result.out_last    = item.end_of_query;
   assign result.short_query = item.end_of_query &&
                               (pos_ff < dqr_pkg::POS_W'(dqr_pkg::HEADER_BYTES - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         cnt_hi_ff <= 1'b0;
         mode_ff   <= WALK_HEADER;
         left_ff   <= '0;
      end else if (advance) begin
         pos_ff    <= pos_in;
         cnt_hi_ff <= cnt_hi_in;
         mode_ff   <= mode_in;
         left_ff   <= left_in;
      end
   end

   `ASSERT_PROP(a_label_nonempty, (mode_ff == WALK_LABEL) |-> (left_ff != '0), "label mode with no bytes left")
   `ASSERT_NEVER(a_pos_range, pos_ff > dqr_pkg::POS_W'(dqr_pkg::HEADER_BYTES), "byte position past header")
   `ASSERT_PROP(a_clear_on_last, (advance && item.end_of_query) |=> (pos_ff == '0 && mode_ff == WALK_HEADER && !cnt_hi_ff), "state not cleared after last byte")

endmodule

/* rtl/core/dns_query_id_and_case_rewriter.sv */
// ----------------------------------------------------------------------------
// dns_query_id_and_case_rewriter
// Replaces the query ID, masks the flags word and randomizes the letter case
// of the first question name of a DNS query, one byte per transfer.
// ----------------------------------------------------------------------------
//   channel | direction | transfer when       | payload
//   req     | in        | req_valid & !stall  | query_byte, end_of_query, new_query_id, random_bit
//   rsp     | out       | rsp_valid & !stall  | out_byte, out_last, short_query
//   csr     | in/out    | psel&penable&pwrite | flags_keep_mask at any address
//
// One byte per cycle sustained while rsp_stall stays low; input register, then result register.
// The rewrite and walk-state update sit between the two registers.
// req_stall rises only when both registers are full and rsp_stall is high.
// Synchronous reset clears the walk state and sets flags_keep_mask to 0x7900.
// ----------------------------------------------------------------------------
module dns_query_id_and_case_rewriter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_query_byte,
   input  logic        req_end_of_query,
   input  logic [15:0] req_new_query_id,
   input  logic        req_random_bit,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_last,
   output logic        rsp_short_query,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic                s1_valid_ff, s1_valid_in;
   dqr_pkg::item_type   s1_item_ff;
   logic                s2_valid_ff, s2_valid_in;
   dqr_pkg::result_type s2_result_ff;
   dqr_pkg::result_type result;
   logic [15:0]         mask_ff;
   logic                accept;
   logic                advance;
   logic                csr_write;
   logic [0:0]          csr_index;

   assign advance     = s1_valid_ff && (!s2_valid_ff || !rsp_stall);
   assign req_stall   = s1_valid_ff && !advance;
   assign accept      = req_valid && !req_stall;
   assign s1_valid_in = accept || (s1_valid_ff && !advance);
   assign s2_valid_in = advance || (s2_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff.query_byte   <= req_query_byte;
         s1_item_ff.end_of_query <= req_end_of_query;
         s1_item_ff.new_query_id <= req_new_query_id;
         s1_item_ff.random_bit   <= req_random_bit;
      end
      if (advance) begin
         s2_result_ff <= result;
      end
   end

   dqr_rewrite u_rewrite (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .item      (s1_item_ff),
      .keep_mask (mask_ff),
      .result    (result)
   );

   assign rsp_valid       = s2_valid_ff;
   assign rsp_out_byte    = s2_result_ff.out_byte;
   assign rsp_out_last    = s2_result_ff.out_last;
   assign rsp_short_query = s2_result_ff.short_query;

   assign csr_index  = csr_paddr[1:1] & 1'b0;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= dqr_pkg::FLAGS_KEEP_MASK_RESET;
      end else if (csr_write && csr_index == dqr_pkg::CSR_FLAGS_KEEP_MASK) begin
         mask_ff <= csr_pwdata[15:0];
      end
   end

   assign csr_prdata = {16'd0, mask_ff};

endmodule
